[rtl/cal_pkg.sv]
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants for the cursor array list
// Sizes, command and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package cal_pkg;

   localparam int CAPACITY   = 32;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam int CMD_W      = 3;
   localparam int ENTRY_W    = 32;
   localparam int COUNT_W    = 6;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;

   localparam int REQ_BITS   = CMD_W + ENTRY_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = COUNT_W + 1 + VALUE_W + STATUS_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_START   = 3'd0,
      CMD_ADVANCE = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_ATTACH  = 3'd3,
      CMD_REMOVE  = 3'd4,
      CMD_QUERY   = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_NOCUR = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SHIFT_HOLD  = 2'd0,
      SHIFT_OPEN  = 2'd1,
      SHIFT_CLOSE = 2'd2
   } shift_type;

   // broadcast to every cell each cycle
   typedef struct packed {
      shift_type         op;
      logic [CNT_W-1:0]  pos;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  rd_pos;
   } cell_ctl_type;

endpackage

`default_nettype wire

[rtl/cal_cell.sv]
// ----------------------------------------------------------------------------
// cal_cell: one slot of the list
// Holds one word; takes the word from its lower or upper neighbor, or the new
// entry, as the broadcast shift command asks, and offers its word on a read hit.
// ----------------------------------------------------------------------------
`default_nettype none

module cal_cell (
   input  wire logic                        clock,
   input  wire logic [cal_pkg::IDX_W-1:0]   cell_index,
   input  wire cal_pkg::cell_ctl_type       ctl,
   input  wire logic [cal_pkg::DATA_W-1:0]  below_data,
   input  wire logic [cal_pkg::DATA_W-1:0]  above_data,
   output logic      [cal_pkg::DATA_W-1:0]  data_out,
   output logic      [cal_pkg::DATA_W-1:0]  rd_data
);
   import cal_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [CNT_W-1:0]  my_pos;

   assign my_pos = CNT_W'(cell_index);

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         SHIFT_OPEN: begin
            if (my_pos > ctl.pos) begin
               data_in = below_data;
            end else if (my_pos == ctl.pos) begin
               data_in = ctl.value;
            end
         end
         SHIFT_CLOSE: begin
            if (my_pos >= ctl.pos) begin
               data_in = above_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign rd_data  = (my_pos == ctl.rd_pos) ? data_ff : '0;

endmodule

`default_nettype wire

[rtl/cursor_array_list_top.sv]
// ----------------------------------------------------------------------------
// cursor_array_list_top: ordered word list with a cursor
// Row of storage cells that shift together on insert, attach and remove.
// ----------------------------------------------------------------------------
// One command is taken per cycle unless a held result blocks it. The command
// updates the cell row, count and cursor at its accept edge; once the output
// register is free, the word under the cursor is picked out of the row and
// loaded into it, and commands may follow back to back
// while the result side keeps taking them. All cells shift in the same cycle,
// so insert and remove cost no more than any other command. No clearing pass
// is needed after reset.
`default_nettype none

module cursor_array_list_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [2:0] cmd, [34:3] entry_value, rest zero
   input  wire logic [cal_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [5:0] item_count, [6] has_current, [38:7] current_value, [40:39] status
   output logic      [cal_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import cal_pkg::*;

   logic                 accept;
   logic                 capture;
   logic [CMD_W-1:0]     req_cmd;
   logic [DATA_W-1:0]    req_value;

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     cursor_ff, cursor_in;
   logic                 pending_ff, pending_in;
   status_type           pstatus_ff, pstatus_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_has_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   status_type           rsp_status_ff;

   logic                 cur_valid;
   logic                 full;
   cell_ctl_type         ctl;
   logic [DATA_W-1:0]    cell_data [CAPACITY];
   logic [DATA_W-1:0]    cell_rd   [CAPACITY];
   logic [DATA_W-1:0]    sel_value;

   assign req_cmd   = req_tdata[CMD_W-1:0];
   assign req_value = DATA_W'(req_tdata[CMD_W+ENTRY_W-1:CMD_W]);

   assign capture    = pending_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pending_ff || capture;
   assign accept     = req_tvalid && req_tready;

   assign cur_valid = cursor_ff < count_ff;
   assign full      = count_ff == CNT_W'(CAPACITY);

   always_comb begin
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      pstatus_in = pstatus_ff;
      pending_in = pending_ff && !capture;
      ctl.op     = SHIFT_HOLD;
      ctl.pos    = '0;
      ctl.value  = req_value;
      ctl.rd_pos = cursor_ff;
      if (accept) begin
         pending_in = 1'b1;
         pstatus_in = ST_OK;
         case (req_cmd)
            CMD_START: begin
               cursor_in = '0;
            end
            CMD_ADVANCE: begin
               if (!cur_valid) begin
                  pstatus_in = ST_NOCUR;
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            CMD_INSERT: begin
               if (full) begin
                  pstatus_in = ST_FULL;
               end else begin
                  ctl.op    = SHIFT_OPEN;
                  ctl.pos   = cur_valid ? cursor_ff : '0;
                  cursor_in = ctl.pos;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_ATTACH: begin
               if (full) begin
                  pstatus_in = ST_FULL;
               end else begin
                  ctl.op    = SHIFT_OPEN;
                  ctl.pos   = cur_valid ? cursor_ff + 1'b1 : count_ff;
                  cursor_in = ctl.pos;
                  count_in  = count_ff + 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (!cur_valid) begin
                  pstatus_in = ST_NOCUR;
               end else begin
                  ctl.op   = SHIFT_CLOSE;
                  ctl.pos  = cursor_ff;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               pstatus_in = ST_OK;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] below;
      logic [DATA_W-1:0] above;
      if (i == 0) begin : g_lo
         assign below = '0;
      end else begin : g_mid_lo
         assign below = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_hi
         assign above = '0;
      end else begin : g_mid_hi
         assign above = cell_data[i+1];
      end
      cal_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctl        (ctl),
         .below_data (below),
         .above_data (above),
         .data_out   (cell_data[i]),
         .rd_data    (cell_rd[i])
      );
   end

   // only the cell at the cursor drives a nonzero word
   always_comb begin
      sel_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_value = sel_value | cell_rd[i];
      end
   end

   assign rsp_valid_in = capture || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pstatus_ff <= pstatus_in;
      if (capture) begin
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_has_ff    <= cur_valid;
         rsp_value_ff  <= cur_valid ? VALUE_W'(sel_value) : '0;
         rsp_status_ff <= pstatus_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_status_ff, rsp_value_ff, rsp_has_ff, rsp_count_ff});

endmodule

`default_nettype wire

[dv/cursor_array_list_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_array_list_top_tb: command stream check of the cursor array list
// Drives list commands, covering the empty-list and full-list cases, cursor
// walks and drains, under changing source gaps and sink back-pressure. Each
// result is compared field by field against a predicted list and cursor.
// ----------------------------------------------------------------------------

module cursor_array_list_top_tb;

   import cal_pkg::*;

   localparam int TOTAL_ITEMS    = 1350;
   localparam int HOLD_CYCLES    = 80;
   localparam int STALL_LIMIT    = 2000;
   localparam int SETTLE_CYCLES  = 8;

   // command codes the block treats as query only
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   // rsp_tdata field offsets
   localparam int RSP_HAS_BIT  = COUNT_W;
   localparam int RSP_VAL_LSB  = COUNT_W + 1;
   localparam int RSP_STAT_LSB = COUNT_W + 1 + VALUE_W;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               has_cur;
      logic [VALUE_W-1:0] value;
      status_type         status;
   } list_view_type;

   class list_scoreboard;
      logic [DATA_W-1:0] words [CAPACITY];
      int unsigned       count_now;
      int unsigned       cursor_now;
      list_view_type     views_due [$];
      int                errors;

      function new();
         count_now  = 0;
         cursor_now = 0;
         errors     = 0;
      endfunction

      function bit has_current();
         return cursor_now < count_now;
      endfunction

      // store w at pos, moving later words up one slot
      function void open_slot(int unsigned pos, logic [DATA_W-1:0] w);
         for (int unsigned k = count_now; k > pos; k--)
            words[k] = words[k-1];
         words[pos] = w;
         count_now++;
      endfunction

      function void note_command(logic [CMD_W-1:0] cmd, logic [ENTRY_W-1:0] entry);
         status_type st;
         list_view_type view;
         st = ST_OK;
         case (cmd)
            CMD_START: cursor_now = 0;
            CMD_ADVANCE: begin
               if (!has_current()) st = ST_NOCUR;
               else cursor_now++;
            end
            CMD_INSERT: begin
               if (count_now >= CAPACITY) st = ST_FULL;
               else begin
                  if (!has_current()) cursor_now = 0;
                  open_slot(cursor_now, entry[DATA_W-1:0]);
               end
            end
            CMD_ATTACH: begin
               if (count_now >= CAPACITY) st = ST_FULL;
               else begin
                  if (!has_current()) cursor_now = count_now;
                  else cursor_now++;
                  open_slot(cursor_now, entry[DATA_W-1:0]);
               end
            end
            CMD_REMOVE: begin
               if (!has_current()) st = ST_NOCUR;
               else begin
                  for (int unsigned k = cursor_now + 1; k < count_now; k++)
                     words[k-1] = words[k];
                  count_now--;
               end
            end
            default: ;
         endcase
         view.count   = count_now[COUNT_W-1:0];
         view.has_cur = has_current();
         view.value   = has_current() ? words[cursor_now] : '0;
         view.status  = st;
         views_due.push_back(view);
      endfunction

      task report_mismatch(string msg);
         $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(logic [RSP_TDATA_W-1:0] tdata);
         list_view_type want;
         if (views_due.size() == 0) begin
            report_mismatch($sformatf("result %h with none expected", tdata));
            return;
         end
         want = views_due.pop_front();
         if (tdata[COUNT_W-1:0] != want.count)
            report_mismatch($sformatf("item_count %0d, want %0d",
                                      tdata[COUNT_W-1:0], want.count));
         if (tdata[RSP_HAS_BIT] != want.has_cur)
            report_mismatch($sformatf("has_current %0b, want %0b",
                                      tdata[RSP_HAS_BIT], want.has_cur));
         if (tdata[RSP_VAL_LSB +: VALUE_W] != want.value)
            report_mismatch($sformatf("current_value %h, want %h",
                                      tdata[RSP_VAL_LSB +: VALUE_W], want.value));
         if (tdata[RSP_STAT_LSB +: STATUS_W] != want.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      tdata[RSP_STAT_LSB +: STATUS_W], want.status));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   list_scoreboard sb = new();

   int sent           = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_granted  = 0;
   int hold_left      = 0;

   cursor_array_list_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sink side: random back-pressure, plus long hold-offs on request
   always @(posedge clock) begin
      if (holds_granted != holds_asked) begin
         holds_granted = holds_asked;
         hold_left     = HOLD_CYCLES;
      end
      if (reset || hold_left > 0) begin
         rsp_tready <= 1'b0;
         if (hold_left > 0) hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_command(req_tdata[CMD_W-1:0], req_tdata[CMD_W +: ENTRY_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata);
      end
   end

   // ends the run once nothing has moved on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_command(logic [CMD_W-1:0] cmd, logic [ENTRY_W-1:0] entry);
      logic [REQ_TDATA_W-1:0] word;
      word = '0;
      word[CMD_W-1:0] = cmd;
      word[CMD_W +: ENTRY_W] = entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   function automatic logic [ENTRY_W-1:0] pick_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [CMD_W-1:0] pick_store_cmd();
      return $urandom_range(1) ? CMD_INSERT : CMD_ATTACH;
   endfunction

   initial begin : stimulus
      int n;
      int hold_idx;
      int hold_marks [2];
      hold_marks = '{300, 1150};
      hold_idx   = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, cursor off the end, spare codes, drain to empty
      send_command(CMD_QUERY,    '0);
      send_command(CMD_START,    '0);
      send_command(CMD_ADVANCE,  '0);
      send_command(CMD_REMOVE,   '0);
      send_command(CMD_INSERT,   '0);
      send_command(CMD_ADVANCE,  '0);
      send_command(CMD_ATTACH,   '1);
      send_command(CMD_INSERT,   32'hA5A5_5A5A);
      send_command(CMD_START,    '0);
      send_command(CMD_INSERT,   32'h0000_0001);
      send_command(CMD_ATTACH,   32'h8000_0000);
      send_command(CMD_ADVANCE,  '0);
      send_command(CMD_ADVANCE,  '0);
      send_command(CMD_ADVANCE,  '0);
      send_command(CMD_INSERT,   32'h7FFF_FFFF);
      send_command(CMD_SPARE_LO, '1);
      send_command(CMD_SPARE_HI, '0);
      send_command(CMD_REMOVE,   '0);
      send_command(CMD_START,    '0);
      repeat (6) send_command(CMD_REMOVE, '0);

      while (sent < TOTAL_ITEMS) begin
         case (sent * 4 / TOTAL_ITEMS)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         if (hold_idx < 2 && sent >= hold_marks[hold_idx]) begin
            holds_asked++;
            hold_idx++;
         end
         case ($urandom_range(9))
            0, 1, 2: begin
               // grow, often up to and past full
               n = $urandom_range(1, 36);
               repeat (n) begin
                  if ($urandom_range(5) == 0)
                     send_command($urandom_range(1) ? CMD_START : CMD_ADVANCE, pick_word());
                  else
                     send_command(pick_store_cmd(), pick_word());
               end
            end
            3, 4: begin
               // walk the cursor from the front past the end
               send_command(CMD_START, pick_word());
               n = $urandom_range(1, 34);
               repeat (n)
                  send_command($urandom_range(4) == 0 ? CMD_QUERY : CMD_ADVANCE,
                               pick_word());
            end
            5, 6: begin
               // shrink, removing at the cursor
               if ($urandom_range(1)) send_command(CMD_START, pick_word());
               n = $urandom_range(1, 34);
               repeat (n)
                  send_command($urandom_range(5) == 0 ? CMD_ADVANCE : CMD_REMOVE,
                               pick_word());
            end
            default: begin
               n = $urandom_range(1, 8);
               repeat (n) send_command(CMD_W'($urandom_range(7)), pick_word());
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (sb.views_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

[filelist.f]
rtl/cal_pkg.sv
rtl/cal_cell.sv
rtl/cursor_array_list_top.sv
dv/cursor_array_list_top_tb.sv
